/* rtl/ptacc_pkg.sv */
package ptacc_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned IntervalW = 8;
  localparam int unsigned OffsetW = 16;

  localparam logic [IntervalW-1:0] EmitIntervalReset = 8'd25;

  localparam logic signed [OffsetW-1:0] OffsetMax = 16'sh7FFF;
  localparam logic signed [OffsetW-1:0] OffsetMin = 16'sh8000;

  typedef enum logic [0:0] {
    RegEmitInterval = 1'b0,
    RegUnmapped     = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    OpUp      = 3'd0,
    OpLeft    = 3'd1,
    OpDown    = 3'd2,
    OpRight   = 3'd3,
    OpRotCcw  = 3'd4,
    OpRotCw   = 3'd5,
    OpMirrorX = 3'd6,
    OpMirrorY = 3'd7
  } op_e;

  typedef struct packed {
    logic                        mirror;
    logic [1:0]                  quarters;
    logic signed [OffsetW-1:0]   off_x;
    logic signed [OffsetW-1:0]   off_y;
  } xform_t;

  localparam xform_t XformIdentity = '{mirror: 1'b0, quarters: 2'd0,
                                       off_x: '0, off_y: '0};

  typedef struct packed {
    logic                  emit;
    logic [IntervalW-1:0]  count;
  } step_ctl_t;

  function automatic logic signed [OffsetW-1:0] sat16(input logic signed [OffsetW:0] v);
    logic signed [OffsetW-1:0] r;
    if (v > (OffsetW+1)'(OffsetMax)) begin
      r = OffsetMax;
    end else if (v < (OffsetW+1)'(OffsetMin)) begin
      r = OffsetMin;
    end else begin
      r = v[OffsetW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [OffsetW-1:0] add_sat(input logic signed [OffsetW-1:0] a,
                                                       input logic signed [OffsetW-1:0] b);
    logic signed [OffsetW:0] s;
    s = (OffsetW+1)'(a) + (OffsetW+1)'(b);
    return sat16(s);
  endfunction

  function automatic logic signed [OffsetW-1:0] sub_sat(input logic signed [OffsetW-1:0] a,
                                                       input logic signed [OffsetW-1:0] b);
    logic signed [OffsetW:0] s;
    s = (OffsetW+1)'(a) - (OffsetW+1)'(b);
    return sat16(s);
  endfunction

  function automatic logic signed [OffsetW-1:0] neg_sat(input logic signed [OffsetW-1:0] v);
    logic signed [OffsetW-1:0] r;
    if (v == OffsetMin) begin
      r = OffsetMax;
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

/* rtl/ptacc_if.sv */
interface ptacc_cmd_if;
  logic                                     valid;
  logic                                     ready;
  logic [2:0]                               operation;
  logic signed [ptacc_pkg::OffsetW-1:0]     amount;

  modport source (output valid, output operation, output amount, input ready);
  modport sink (input valid, input operation, input amount, output ready);
endinterface

interface ptacc_res_if;
  logic                                     valid;
  logic                                     ready;
  logic [1:0]                               rotate_ccw_quarters;
  logic                                     mirror_y;
  logic signed [ptacc_pkg::OffsetW-1:0]     shift_right;
  logic signed [ptacc_pkg::OffsetW-1:0]     shift_up;

  modport source (output valid, output rotate_ccw_quarters, output mirror_y,
                  output shift_right, output shift_up, input ready);
  modport sink (input valid, input rotate_ccw_quarters, input mirror_y,
                input shift_right, input shift_up, output ready);
endinterface

/* rtl/planar_transform_accumulator_core.sv */
// Planar transform accumulator.
// Commands arrive on the cmd channel (valid/ready); each transaction carries
// an operation code and a signed 16-bit amount and is composed onto a kept
// 2D transform (signed-permutation linear part plus saturating translation).
// After every emit_interval commands (after each one when it is 0) the
// composed transform leaves on the res channel as quarter turns, a Y mirror
// flag and right/up shifts, and the kept transform returns to identity.
// emit_interval sits at byte address 0 of the APB port; write it only while
// the block is idle.
// A command is registered at acceptance and composed once the result stage
// can take it; a result it causes is registered in the result stage and
// holds there until the receiver takes it.
// Throughput: one command per cycle while the receiver takes results, set
// by the single compose stage between command and state/result registers.
// Reset clears the transform, the command count and both channel stages and
// loads emit_interval with 25.
// When the receiver stalls, the result holds; one command waits in the
// command register, and cmd.ready drops until the result is taken.
module planar_transform_accumulator_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ptacc_cmd_if.sink                       cmd,
  ptacc_res_if.source                     res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ptacc_pkg::CfgAddrW-1:0]  paddr,
  input  logic [ptacc_pkg::CfgDataW-1:0]  pwdata,
  output logic [ptacc_pkg::CfgDataW-1:0]  prdata,
  output logic                            pready
);

  logic [ptacc_pkg::IntervalW-1:0]      emit_interval;

  logic                                 in_valid_q;
  logic                                 in_valid_d;
  ptacc_pkg::op_e                       op_q;
  logic signed [ptacc_pkg::OffsetW-1:0] amount_q;
  logic                                 in_take;
  logic                                 proc;

  ptacc_pkg::xform_t                    xform_q;
  ptacc_pkg::xform_t                    xform_d;
  logic [ptacc_pkg::IntervalW-1:0]      count_q;
  logic [ptacc_pkg::IntervalW-1:0]      count_d;
  ptacc_pkg::xform_t                    xform_next;
  ptacc_pkg::step_ctl_t                 step_ctl;

  logic                                 out_valid_q;
  logic                                 out_valid_d;
  ptacc_pkg::xform_t                    out_q;

  ptacc_regs u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .emit_interval_o (emit_interval)
  );

  ptacc_step u_step (
    .cur_i      (xform_q),
    .op_i       (op_q),
    .amount_i   (amount_q),
    .count_i    (count_q),
    .interval_i (emit_interval),
    .next_o     (xform_next),
    .ctl_o      (step_ctl)
  );

  assign proc      = in_valid_q && (!out_valid_q || res.ready);
  assign cmd.ready = !in_valid_q || proc;
  assign in_take   = cmd.valid && cmd.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    xform_d     = xform_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !res.ready;
    if (proc) begin
      if (step_ctl.emit) begin
        xform_d     = ptacc_pkg::XformIdentity;
        count_d     = '0;
        out_valid_d = 1'b1;
      end else begin
        xform_d = xform_next;
        count_d = step_ctl.count;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      xform_q     <= ptacc_pkg::XformIdentity;
      count_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      xform_q     <= xform_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q     <= ptacc_pkg::op_e'(cmd.operation);
      amount_q <= cmd.amount;
    end
    if (proc && step_ctl.emit) begin
      out_q <= xform_next;
    end
  end

  assign res.valid               = out_valid_q;
  assign res.rotate_ccw_quarters = out_q.quarters;
  assign res.mirror_y            = out_q.mirror;
  assign res.shift_right         = out_q.off_x;
  assign res.shift_up            = out_q.off_y;

endmodule

/* rtl/ptacc_regs.sv */
module ptacc_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ptacc_pkg::CfgAddrW-1:0]      paddr,
  input  logic [ptacc_pkg::CfgDataW-1:0]      pwdata,
  output logic [ptacc_pkg::CfgDataW-1:0]      prdata,
  output logic                                pready,
  output logic [ptacc_pkg::IntervalW-1:0]     emit_interval_o
);

  logic [ptacc_pkg::IntervalW-1:0] interval_q;
  logic [ptacc_pkg::IntervalW-1:0] interval_d;
  ptacc_pkg::reg_idx_e             reg_idx;
  logic                            wr_en;

  assign reg_idx = ptacc_pkg::reg_idx_e'(paddr[ptacc_pkg::CfgAddrW-1]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    interval_d = interval_q;
    if (wr_en && (reg_idx == ptacc_pkg::RegEmitInterval)) begin
      interval_d = pwdata[ptacc_pkg::IntervalW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= ptacc_pkg::EmitIntervalReset;
    end else begin
      interval_q <= interval_d;
    end
  end

  always_comb begin
    case (reg_idx)
      ptacc_pkg::RegEmitInterval: prdata = ptacc_pkg::CfgDataW'(interval_q);
      default:                    prdata = '0;
    endcase
  end

  assign emit_interval_o = interval_q;

endmodule

/* rtl/ptacc_step.sv */
module ptacc_step (
  input  ptacc_pkg::xform_t                   cur_i,
  input  ptacc_pkg::op_e                      op_i,
  input  logic signed [ptacc_pkg::OffsetW-1:0] amount_i,
  input  logic [ptacc_pkg::IntervalW-1:0]     count_i,
  input  logic [ptacc_pkg::IntervalW-1:0]     interval_i,
  output ptacc_pkg::xform_t                   next_o,
  output ptacc_pkg::step_ctl_t                ctl_o
);

  logic [1:0]                          rot;
  logic                                is_rot;
  logic signed [ptacc_pkg::OffsetW-1:0] nx;
  logic signed [ptacc_pkg::OffsetW-1:0] ny;

  always_comb begin
    rot    = 2'd0;
    is_rot = 1'b0;
    next_o = cur_i;
    case (op_i)
      ptacc_pkg::OpUp:    next_o.off_y = ptacc_pkg::add_sat(cur_i.off_y, amount_i);
      ptacc_pkg::OpLeft:  next_o.off_x = ptacc_pkg::sub_sat(cur_i.off_x, amount_i);
      ptacc_pkg::OpDown:  next_o.off_y = ptacc_pkg::sub_sat(cur_i.off_y, amount_i);
      ptacc_pkg::OpRight: next_o.off_x = ptacc_pkg::add_sat(cur_i.off_x, amount_i);
      ptacc_pkg::OpRotCcw: begin
        is_rot = 1'b1;
        rot    = amount_i[1:0];
      end
      ptacc_pkg::OpRotCw: begin
        is_rot = 1'b1;
        rot    = 2'd0 - amount_i[1:0];
      end
      ptacc_pkg::OpMirrorX: begin
        next_o.off_y    = ptacc_pkg::neg_sat(cur_i.off_y);
        next_o.mirror   = ~cur_i.mirror;
        next_o.quarters = cur_i.quarters + 2'd2;
      end
      default: begin
        next_o.off_x  = ptacc_pkg::neg_sat(cur_i.off_x);
        next_o.mirror = ~cur_i.mirror;
      end
    endcase

    nx = cur_i.off_x;
    ny = cur_i.off_y;
    case (rot)
      2'd1: begin
        nx = ptacc_pkg::neg_sat(cur_i.off_y);
        ny = cur_i.off_x;
      end
      2'd2: begin
        nx = ptacc_pkg::neg_sat(cur_i.off_x);
        ny = ptacc_pkg::neg_sat(cur_i.off_y);
      end
      2'd3: begin
        nx = cur_i.off_y;
        ny = ptacc_pkg::neg_sat(cur_i.off_x);
      end
      default: ;
    endcase

    if (is_rot) begin
      next_o.off_x    = nx;
      next_o.off_y    = ny;
      next_o.quarters = cur_i.mirror ? (cur_i.quarters - rot) : (cur_i.quarters + rot);
    end
  end

  always_comb begin
    ctl_o.count = count_i + 1'b1;
    ctl_o.emit  = (ctl_o.count >= interval_i);
  end

endmodule

/* rtl/ptacc_checker.sv */
module ptacc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cmd_valid,
  input logic                            cmd_ready,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic [1:0]                      res_quarters,
  input logic                            res_mirror,
  input logic [ptacc_pkg::OffsetW-1:0]   res_right,
  input logic [ptacc_pkg::OffsetW-1:0]   res_up
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_quarters) &&
    $stable(res_mirror) && $stable(res_right) && $stable(res_up))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid |-> cmd_ready)
    else $error("command stalled with empty result stage");

  a_res_from_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid) |-> $past(cmd_valid && cmd_ready, 2))
    else $error("result without a command two cycles earlier");

endmodule

bind planar_transform_accumulator_core ptacc_checker u_ptacc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_quarters (res.rotate_ccw_quarters),
  .res_mirror   (res.mirror_y),
  .res_right    (res.shift_right),
  .res_up       (res.shift_up)
);

/* tb/sv/testbench.sv */
module testbench;

  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [1:0]                           quarters;
    logic                                 mirror;
    logic signed [ptacc_pkg::OffsetW-1:0] right;
    logic signed [ptacc_pkg::OffsetW-1:0] up;
  } composed_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [ptacc_pkg::CfgAddrW-1:0] paddr;
  logic [ptacc_pkg::CfgDataW-1:0] pwdata;
  logic [ptacc_pkg::CfgDataW-1:0] prdata;
  logic                           pready;

  ptacc_cmd_if cmd_bus ();
  ptacc_res_if res_bus ();

  planar_transform_accumulator_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd     (cmd_bus),
    .res     (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicted block state
  logic                                 kept_mirror;
  logic [1:0]                           kept_quarters;
  logic signed [ptacc_pkg::OffsetW-1:0] kept_x;
  logic signed [ptacc_pkg::OffsetW-1:0] kept_y;
  logic [ptacc_pkg::IntervalW-1:0]      cmd_count;
  logic [ptacc_pkg::IntervalW-1:0]      emit_interval;

  composed_t expected_xforms[$];
  composed_t oldest_xform;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned hold_left;
  int unsigned stall_pct;
  int unsigned gap_max;
  int unsigned burst_left;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int clamp16(input int v);
    if (v > 32767) begin
      return 32767;
    end else if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  function automatic bit compose_command(input ptacc_pkg::op_e op,
                                         input logic signed [ptacc_pkg::OffsetW-1:0] amt,
                                         output composed_t xf);
    int x;
    int y;
    int x_new;
    int y_new;
    logic [1:0] turns;
    x = kept_x;
    y = kept_y;
    x_new = 0;
    y_new = 0;
    turns = 2'd0;
    xf = '0;
    case (op)
      ptacc_pkg::OpUp: y = clamp16(y + amt);
      ptacc_pkg::OpLeft: x = clamp16(x - amt);
      ptacc_pkg::OpDown: y = clamp16(y - amt);
      ptacc_pkg::OpRight: x = clamp16(x + amt);
      ptacc_pkg::OpRotCcw: turns = amt[1:0];
      ptacc_pkg::OpRotCw: turns = 2'd0 - amt[1:0];
      ptacc_pkg::OpMirrorX: begin
        y = clamp16(-y);
        kept_mirror = !kept_mirror;
        kept_quarters = kept_quarters + 2'd2;
      end
      default: begin
        x = clamp16(-x);
        kept_mirror = !kept_mirror;
      end
    endcase
    if (turns != 2'd0) begin
      case (turns)
        2'd1: begin
          x_new = -y;
          y_new = x;
        end
        2'd2: begin
          x_new = -x;
          y_new = -y;
        end
        default: begin
          x_new = y;
          y_new = -x;
        end
      endcase
      x = clamp16(x_new);
      y = clamp16(y_new);
      kept_quarters = kept_mirror ? kept_quarters - turns : kept_quarters + turns;
    end
    kept_x = x[ptacc_pkg::OffsetW-1:0];
    kept_y = y[ptacc_pkg::OffsetW-1:0];
    cmd_count = cmd_count + 8'd1;
    if (cmd_count < emit_interval) begin
      return 1'b0;
    end
    xf.quarters = kept_quarters;
    xf.mirror = kept_mirror;
    xf.right = kept_x;
    xf.up = kept_y;
    kept_mirror = 1'b0;
    kept_quarters = 2'd0;
    kept_x = '0;
    kept_y = '0;
    cmd_count = '0;
    return 1'b1;
  endfunction

  function automatic logic signed [ptacc_pkg::OffsetW-1:0] pick_amount();
    case ($urandom_range(0, 9))
      0: return ptacc_pkg::OffsetMax;
      1: return ptacc_pkg::OffsetMin;
      2, 3, 4, 5: return ptacc_pkg::OffsetW'($urandom_range(0, 64)) - 16'sd32;
      default: return ptacc_pkg::OffsetW'($urandom);
    endcase
  endfunction

  task automatic flag_error(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  task automatic send_cmd(input ptacc_pkg::op_e op,
                          input logic signed [ptacc_pkg::OffsetW-1:0] amt);
    composed_t xf;
    int unsigned gap;
    if (gap_max != 0 && burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      repeat (gap) begin
        @(negedge clk_i);
        cmd_bus.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left != 0) begin
      burst_left--;
    end
    @(negedge clk_i);
    cmd_bus.valid <= 1'b1;
    cmd_bus.operation <= op;
    cmd_bus.amount <= amt;
    do @(posedge clk_i); while (!cmd_bus.ready);
    if (compose_command(op, amt, xf)) begin
      expected_xforms.push_back(xf);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    cmd_bus.valid <= 1'b0;
    while (expected_xforms.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(input ptacc_pkg::reg_idx_e idx,
                           input logic [ptacc_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ptacc_pkg::CfgAddrW'(idx) << 2;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == ptacc_pkg::RegEmitInterval) begin
      emit_interval = data[ptacc_pkg::IntervalW-1:0];
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_interval();
    logic [ptacc_pkg::CfgDataW-1:0] data;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ptacc_pkg::CfgAddrW'(ptacc_pkg::RegEmitInterval) << 2;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (data[ptacc_pkg::IntervalW-1:0] !== emit_interval) begin
      flag_error("emit_interval readback", data[ptacc_pkg::IntervalW-1:0], emit_interval);
    end
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) begin
      send_cmd(ptacc_pkg::op_e'($urandom_range(0, 7)), pick_amount());
    end
  endtask

  task automatic test_reset_state();
    check_interval();
    stall_pct = 30;
    gap_max = 4;
    run_random(25);
    wait_idle();
  endtask

  task automatic test_register_access();
    apb_write(ptacc_pkg::RegEmitInterval, 32'h0000_00A5);
    check_interval();
    apb_write(ptacc_pkg::RegUnmapped, 32'h0000_0007);
    check_interval();
    apb_write(ptacc_pkg::RegEmitInterval, 32'hFFFF_FF5A);
    check_interval();
  endtask

  task automatic test_each_operation();
    stall_pct = 0;
    gap_max = 0;
    apb_write(ptacc_pkg::RegEmitInterval, 32'd1);
    send_cmd(ptacc_pkg::OpUp, ptacc_pkg::OffsetMax);
    send_cmd(ptacc_pkg::OpUp, ptacc_pkg::OffsetMin);
    send_cmd(ptacc_pkg::OpLeft, ptacc_pkg::OffsetMin);
    send_cmd(ptacc_pkg::OpLeft, ptacc_pkg::OffsetMax);
    send_cmd(ptacc_pkg::OpDown, ptacc_pkg::OffsetMin);
    send_cmd(ptacc_pkg::OpDown, 16'sd1);
    send_cmd(ptacc_pkg::OpRight, ptacc_pkg::OffsetMax);
    send_cmd(ptacc_pkg::OpRight, ptacc_pkg::OffsetMin);
    send_cmd(ptacc_pkg::OpRotCcw, ptacc_pkg::OffsetMin);
    send_cmd(ptacc_pkg::OpRotCcw, 16'sd1);
    send_cmd(ptacc_pkg::OpRotCcw, ptacc_pkg::OffsetMax);
    send_cmd(ptacc_pkg::OpRotCw, -16'sd1);
    send_cmd(ptacc_pkg::OpRotCw, 16'sd2);
    send_cmd(ptacc_pkg::OpMirrorX, 16'sh5555);
    send_cmd(ptacc_pkg::OpMirrorY, -16'sd1);
    wait_idle();
    apb_write(ptacc_pkg::RegEmitInterval, 32'd3);
    send_cmd(ptacc_pkg::OpRight, ptacc_pkg::OffsetMax);
    send_cmd(ptacc_pkg::OpRight, 16'sd1);
    send_cmd(ptacc_pkg::OpRotCcw, 16'sd2);
    send_cmd(ptacc_pkg::OpRight, ptacc_pkg::OffsetMin);
    send_cmd(ptacc_pkg::OpMirrorY, 16'sd0);
    send_cmd(ptacc_pkg::OpUp, ptacc_pkg::OffsetMax);
    send_cmd(ptacc_pkg::OpUp, ptacc_pkg::OffsetMin);
    send_cmd(ptacc_pkg::OpRotCcw, 16'sd1);
    send_cmd(ptacc_pkg::OpMirrorX, -16'sh2AAB);
    wait_idle();
  endtask

  task automatic test_zero_interval();
    apb_write(ptacc_pkg::RegEmitInterval, 32'd0);
    check_interval();
    stall_pct = 40;
    gap_max = 3;
    run_random(6);
    wait_idle();
  endtask

  task automatic test_interval_lowered();
    apb_write(ptacc_pkg::RegEmitInterval, 32'd10);
    run_random(7);
    wait_idle();
    apb_write(ptacc_pkg::RegEmitInterval, 32'd3);
    run_random(4);
    wait_idle();
  endtask

  task automatic test_backpressure();
    apb_write(ptacc_pkg::RegEmitInterval, 32'd1);
    stall_pct = 0;
    gap_max = 0;
    hold_left = 80;
    run_random(40);
    wait_idle();
  endtask

  task automatic test_random_phases();
    apb_write(ptacc_pkg::RegEmitInterval, 32'd1);
    stall_pct = 50;
    gap_max = 6;
    run_random(80);
    wait_idle();
    apb_write(ptacc_pkg::RegEmitInterval, 32'd3);
    stall_pct = 0;
    gap_max = 0;
    run_random(40);
    wait_idle();
    apb_write(ptacc_pkg::RegEmitInterval, 32'd7);
    stall_pct = 70;
    gap_max = 2;
    run_random(50);
    wait_idle();
    apb_write(ptacc_pkg::RegEmitInterval, 32'd255);
    check_interval();
    stall_pct = 20;
    gap_max = 5;
    run_random(256);
    wait_idle();
    repeat (8) begin
      apb_write(ptacc_pkg::RegEmitInterval, $urandom_range(1, 16));
      stall_pct = $urandom_range(0, 80);
      gap_max = $urandom_range(0, 8);
      run_random(15);
      wait_idle();
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      res_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      res_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (expected_xforms.size() == 0) begin
        flag_error("unexpected result, shift_right", res_bus.shift_right, 0);
      end else begin
        oldest_xform = expected_xforms.pop_front();
        if (res_bus.rotate_ccw_quarters !== oldest_xform.quarters) begin
          flag_error("rotate_ccw_quarters", res_bus.rotate_ccw_quarters, oldest_xform.quarters);
        end
        if (res_bus.mirror_y !== oldest_xform.mirror) begin
          flag_error("mirror_y", res_bus.mirror_y, oldest_xform.mirror);
        end
        if (res_bus.shift_right !== oldest_xform.right) begin
          flag_error("shift_right", res_bus.shift_right, oldest_xform.right);
        end
        if (res_bus.shift_up !== oldest_xform.up) begin
          flag_error("shift_up", res_bus.shift_up, oldest_xform.up);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd_bus.valid = 1'b0;
    cmd_bus.operation = '0;
    cmd_bus.amount = '0;
    res_bus.ready = 1'b0;
    kept_mirror = 1'b0;
    kept_quarters = 2'd0;
    kept_x = '0;
    kept_y = '0;
    cmd_count = '0;
    emit_interval = ptacc_pkg::EmitIntervalReset;
    error_count = 0;
    hold_left = 0;
    stall_pct = 0;
    gap_max = 0;
    burst_left = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_register_access();
    test_each_operation();
    test_zero_interval();
    test_interval_lowered();
    test_backpressure();
    test_random_phases();
    wait_idle();
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
